@@ sv/qph_pkg.sv @@
// Shared types and constants for the quadratic-probe key/value table.
// No dependencies; every other file of the block imports this package.
package qph_pkg;

  localparam int DEF_TABLE_SLOTS = 1024;

  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 64;
  localparam int OCC_W    = 11;
  localparam int STATUS_W = 3;

  // Key reduction modulo the slot count runs one key byte per cycle.
  localparam int RED_DIGIT_W = 8;
  localparam int RED_STEPS   = KEY_W / RED_DIGIT_W;

  localparam logic CMD_GET = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4
  } status_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic    clr;     // clear one slot of the store
    logic    load;    // capture the item, start the key reduction
    logic    seat;    // set the first probe position
    logic    adv;     // advance to the next probe position
    logic    commit;  // write the store on insert or update, load the result
    status_t code;    // result code for commit
  } qph_ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;
    logic red_done;
    logic match;     // probed slot is used and holds the key
    logic free;      // probed slot is unused
    logic last;      // current probe is the last one
    logic is_get;
  } qph_sts_t;

endpackage

@@ sv/qph_if.sv @@
// Request and response channel interfaces (valid/ready with payload).
// Depends on qph_pkg for the field widths.
interface qph_req_if;
  import qph_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink (input valid, input cmd, input key, input value, output ready);
endinterface

interface qph_rsp_if;
  import qph_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  read_value;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output read_value, output occupancy,
                  input ready);
  modport sink (input valid, input status, input read_value, input occupancy,
                output ready);
endinterface

@@ sv/qph_reduce.sv @@
// Multi-cycle reduction of a 64-bit key modulo the slot count, one byte per cycle.
// Depends on qph_pkg; a power-of-two slot count takes the low key bits directly.
module qph_reduce #(
  parameter int TABLE_SLOTS = qph_pkg::DEF_TABLE_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [qph_pkg::KEY_W-1:0]      key,
  output logic                           done,
  output logic [$clog2(TABLE_SLOTS)-1:0] rem
);
  import qph_pkg::*;

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam int X_W     = SLOT_W + RED_DIGIT_W;
  localparam int CNT_W   = $clog2(RED_STEPS + 1);
  localparam logic [X_W-1:0] SLOTS_X = X_W'(TABLE_SLOTS);

  logic [KEY_W-1:0] digits;
  logic [CNT_W-1:0] cnt;
  logic [X_W-1:0]   x;

  // Restoring reduction of {rem, next byte}, which stays below 256 * slots.
  always_comb begin
    x = {rem, digits[KEY_W-1 -: RED_DIGIT_W]};
    for (int b = RED_DIGIT_W - 1; b >= 0; b--) begin
      if (x >= (SLOTS_X << b)) x = x - (SLOTS_X << b);
    end
  end

  assign done = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= IS_POW2 ? CNT_W'(0) : CNT_W'(RED_STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      digits <= key;
      rem    <= IS_POW2 ? key[SLOT_W-1:0] : '0;
    end else if (cnt != '0) begin
      digits <= digits << RED_DIGIT_W;
      rem    <= x[SLOT_W-1:0];
    end
  end
endmodule

@@ sv/qph_dpath.sv @@
// Datapath: slot store memory, probe position arithmetic, key count and result.
// Depends on qph_pkg and qph_reduce; driven by qph_ctrl commands.
module qph_dpath #(
  parameter int TABLE_SLOTS = qph_pkg::DEF_TABLE_SLOTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  qph_pkg::qph_ctl_t            ctl,
  output qph_pkg::qph_sts_t            sts,
  input  logic                         item_cmd,
  input  logic [qph_pkg::KEY_W-1:0]    item_key,
  input  logic [qph_pkg::VALUE_W-1:0]  item_value,
  output logic [qph_pkg::STATUS_W-1:0] res_status,
  output logic [qph_pkg::VALUE_W-1:0]  res_value,
  output logic [qph_pkg::OCC_W-1:0]    occupancy
);
  import qph_pkg::*;

  localparam int SLOT_W   = $clog2(TABLE_SLOTS);
  localparam int WORD_W   = 1 + KEY_W + VALUE_W;
  localparam int USED_BIT = WORD_W - 1;

  // 2^64 mod slots, for probe sums that wrap past 64 bits.
  localparam logic [KEY_W-1:0] HALF_MOD = {1'b1, {(KEY_W-1){1'b0}}} % TABLE_SLOTS;
  localparam logic [KEY_W-1:0] WRAP_MOD = (HALF_MOD << 1) % TABLE_SLOTS;
  localparam logic [SLOT_W:0]  WRAP_ADJ = WRAP_MOD[SLOT_W:0];
  localparam logic [SLOT_W:0]  SLOTS_V  = (SLOT_W + 1)'(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_I  = SLOT_W'(TABLE_SLOTS - 1);

  logic [WORD_W-1:0] mem [TABLE_SLOTS];

  logic               op;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] val_r;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  idx;
  logic [KEY_W-1:0]   pos;
  logic [SLOT_W-1:0]  clr_cnt;
  logic [WORD_W-1:0]  rd_word;
  logic [OCC_W-1:0]   key_count;

  logic [SLOT_W-1:0]  base;
  logic               red_done;
  logic [SLOT_W:0]    step_d;
  logic [SLOT_W:0]    d_mod;
  logic [SLOT_W:0]    sum;
  logic [SLOT_W-1:0]  slot_next;
  logic [KEY_W:0]     pos_sum;
  logic               we;
  logic [SLOT_W-1:0]  waddr;
  logic [WORD_W-1:0]  wdata;

  qph_reduce #(.TABLE_SLOTS(TABLE_SLOTS)) u_reduce (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.load),
    .key   (item_key),
    .done  (red_done),
    .rem   (base)
  );

  // Probe i+1 = probe i + (2i+1); the slot follows mod slots, with a fix-up when
  // the 64-bit position wraps.
  always_comb begin
    step_d  = {idx, 1'b1};
    d_mod   = (step_d >= SLOTS_V) ? step_d - SLOTS_V : step_d;
    pos_sum = {1'b0, pos} + (KEY_W + 1)'(step_d);
    sum     = {1'b0, slot} + d_mod;
    if (sum >= SLOTS_V) sum = sum - SLOTS_V;
    if (pos_sum[KEY_W]) begin
      if (sum >= WRAP_ADJ) sum = sum - WRAP_ADJ;
      else sum = sum + SLOTS_V - WRAP_ADJ;
    end
    slot_next = sum[SLOT_W-1:0];
  end

  always_comb begin
    sts.clr_last = (clr_cnt == LAST_I);
    sts.red_done = red_done;
    sts.match    = rd_word[USED_BIT] && (rd_word[VALUE_W +: KEY_W] == key_r);
    sts.free     = !rd_word[USED_BIT];
    sts.last     = (idx == LAST_I);
    sts.is_get   = (op == CMD_GET);
  end

  assign we    = ctl.clr || (ctl.commit && (ctl.code == ST_INSERTED ||
                                            ctl.code == ST_UPDATED));
  assign waddr = ctl.clr ? clr_cnt : slot;
  assign wdata = ctl.clr ? '0 : {1'b1, key_r, val_r};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_word <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      key_count <= '0;
    end else begin
      if (ctl.clr) clr_cnt <= clr_cnt + 1'b1;
      if (ctl.commit && ctl.code == ST_INSERTED) key_count <= key_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op    <= item_cmd;
      key_r <= item_key;
      val_r <= item_value;
    end
    if (ctl.seat) begin
      slot <= base;
      idx  <= '0;
      pos  <= key_r;
    end else if (ctl.adv) begin
      slot <= slot_next;
      idx  <= idx + 1'b1;
      pos  <= pos_sum[KEY_W-1:0];
    end
    if (ctl.commit) begin
      res_status <= ctl.code;
      res_value  <= (ctl.code == ST_HIT) ? rd_word[VALUE_W-1:0] : '0;
    end
  end

  assign occupancy = key_count;
endmodule

@@ sv/qph_ctrl.sv @@
// Controller: clearing pass, item intake, probe sequencing and result handoff.
// Depends on qph_pkg; pairs with qph_dpath through qph_ctl_t / qph_sts_t.
module qph_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  qph_pkg::qph_sts_t sts,
  output qph_pkg::qph_ctl_t ctl,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready
);
  import qph_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_READ,
    S_CHECK
  } state_t;

  state_t state, state_next;
  logic   finish;
  logic   out_free;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    ctl.clr    = 1'b0;
    ctl.load   = 1'b0;
    ctl.seat   = 1'b0;
    ctl.adv    = 1'b0;
    ctl.commit = 1'b0;
    ctl.code   = ST_MISS;
    case (state)
      S_CLEAR: begin
        ctl.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          ctl.load   = 1'b1;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (sts.red_done) begin
          ctl.seat   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        // A get skips unused slots; a put stops at the first unused one.
        if (sts.is_get) begin
          if (sts.match) begin
            finish   = 1'b1;
            ctl.code = ST_HIT;
          end else if (sts.last) begin
            finish   = 1'b1;
            ctl.code = ST_MISS;
          end
        end else begin
          if (sts.free) begin
            finish   = 1'b1;
            ctl.code = ST_INSERTED;
          end else if (sts.match) begin
            finish   = 1'b1;
            ctl.code = ST_UPDATED;
          end else if (sts.last) begin
            finish   = 1'b1;
            ctl.code = ST_FULL;
          end
        end
        if (finish) begin
          // Hold on this slot until the result register is free.
          if (out_free) begin
            ctl.commit = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          ctl.adv    = 1'b1;
          state_next = S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.commit) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end
endmodule

@@ sv/quadratic_probe_hash_table.sv @@
// Quadratic-probe key/value table: controller plus datapath around one slot memory.
// Flow: an accepted item goes through key-byte reduction when TABLE_SLOTS is not a
//   power of two, then one memory read and one compare per probe, then the result
//   register; a new item is taken only after the last one is committed.
// Reset: synchronous; a clearing pass marks every slot unused before any item is taken.
module quadratic_probe_hash_table #(
  parameter int TABLE_SLOTS = qph_pkg::DEF_TABLE_SLOTS
) (
  input logic      clk,
  input logic      rst,
  qph_req_if.sink  req,
  qph_rsp_if.source rsp
);
  import qph_pkg::*;

  qph_ctl_t ctl;
  qph_sts_t sts;

  // Sequencer: one item in flight; the result register lets the next item start
  // while the previous result still waits on the response side.
  qph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sts       (sts),
    .ctl       (ctl),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
  );

  // Store, probe arithmetic and result register.
  qph_dpath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .item_cmd   (req.cmd),
    .item_key   (req.key),
    .item_value (req.value),
    .res_status (rsp.status),
    .res_value  (rsp.read_value),
    .occupancy  (rsp.occupancy)
  );

`ifndef ASSERT_OFF
  // Only one item at a time: intake closes right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("item accepted while another is in flight");

  // Never overwrite a result that has not been taken.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> (!rsp.valid || rsp.ready))
    else $error("result overwritten before it was taken");

  // Only a get hit carries a value.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_HIT |-> rsp.read_value == '0)
    else $error("nonzero value on a result other than a get hit");
`endif
endmodule
